// ----- rtl/csd_pkg.sv -----
package csd_pkg;

	localparam int MainW  = 10;
	localparam int ToneW  = 12;
	localparam int SpeedW = 9;

	// Main carrier codes in tenths of hertz that gate the tone-edge braking
	localparam logic [MainW-1:0] MAIN_KV65  = 10'd246;
	localparam logic [MainW-1:0] MAIN_CARRE = 10'd290;

	// Secondary tones
	localparam logic [ToneW-1:0] TONE_SECTION_SET  = 12'd1318;
	localparam logic [ToneW-1:0] TONE_SECTION_CLR  = 12'd1319;
	localparam logic [ToneW-1:0] TONE_PANTO_SET    = 12'd3725;
	localparam logic [ToneW-1:0] TONE_PANTO_CLR    = 12'd3726;
	localparam logic [ToneW-1:0] TONE_CARRE        = 12'd1882;
	localparam logic [ToneW-1:0] TONE_KV65         = 12'd3571;
	localparam logic [ToneW-1:0] TONE_DISARM_TWO_A = 12'd2867;
	localparam logic [ToneW-1:0] TONE_DISARM_TWO_B = 12'd3008;
	localparam logic [ToneW-1:0] TONE_ARM_TWO_A    = 12'd3290;
	localparam logic [ToneW-1:0] TONE_ARM_TWO_B    = 12'd2163;
	localparam logic [ToneW-1:0] TONE_ARM_ONE_A    = 12'd3430;
	localparam logic [ToneW-1:0] TONE_ARM_ONE_B    = 12'd2726;

	// Side tones
	localparam logic [ToneW-1:0] SIDE_ONE_A = 12'd1700;
	localparam logic [ToneW-1:0] SIDE_ONE_B = 12'd2300;
	localparam logic [ToneW-1:0] SIDE_TWO_A = 12'd2000;
	localparam logic [ToneW-1:0] SIDE_TWO_B = 12'd2600;

	// Active side codes
	localparam logic [1:0] SIDE_NONE  = 2'd0;
	localparam logic [1:0] SIDE_ONE   = 2'd1;
	localparam logic [1:0] SIDE_TWO   = 2'd2;
	localparam logic [1:0] SIDE_UNDET = 2'd3;

	localparam logic [3:0] ASPECT_NONE = 4'd0;

	typedef struct packed {
		logic [MainW-1:0]  main_freq_tenths;
		logic [ToneW-1:0]  secondary_freq;
		logic [ToneW-1:0]  side_freq;
		logic [SpeedW-1:0] train_speed;
	} item_t;

	typedef struct packed {
		logic [3:0] aspect_code;
		logic       aspect_changed;
		logic       overspeed;
		logic       section_flag;
		logic       pantograph_flag;
		logic [1:0] active_side;
		logic       emergency_brake;
	} result_t;

	typedef struct packed {
		logic              hit;
		logic [3:0]        code;
		logic [SpeedW-1:0] limit;
	} aspect_entry_t;

	typedef struct packed {
		logic       section;
		logic       pantograph;
		logic [1:0] side;
		logic       kv_edge;
		logic       square_edge;
	} tone_res_t;

	// Main code to aspect number (table order 300V..RRRR) and its speed limit
	function automatic aspect_entry_t aspect_lookup(input logic [MainW-1:0] f);
		aspect_entry_t e;
		e = '{hit: 1'b1, code: ASPECT_NONE, limit: '0};
		unique case (f)
			10'd114: begin e.code = 4'd1;  e.limit = 9'd315; end
			10'd136: begin e.code = 4'd2;  e.limit = 9'd315; end
			10'd103: begin e.code = 4'd3;  e.limit = 9'd285; end
			10'd125: begin e.code = 4'd4;  e.limit = 9'd285; end
			10'd169: begin e.code = 4'd5;  e.limit = 9'd315; end
			10'd147: begin e.code = 4'd6;  e.limit = 9'd285; end
			10'd158: begin e.code = 4'd7;  e.limit = 9'd235; end
			10'd180: begin e.code = 4'd8;  e.limit = 9'd235; end
			10'd191: begin e.code = 4'd9;  e.limit = 9'd170; end
			10'd202: begin e.code = 4'd10; e.limit = 9'd170; end
			10'd224: begin e.code = 4'd11; e.limit = 9'd90;  end
			10'd246: begin e.code = 4'd12; e.limit = 9'd90;  end
			10'd290: begin e.code = 4'd13; e.limit = 9'd35;  end
			default: e.hit = 1'b0;
		endcase
		return e;
	endfunction

endpackage

// ----- rtl/csd_aspect_dec.sv -----
module csd_aspect_dec (
	input  logic [csd_pkg::MainW-1:0]  main_freq_tenths,
	input  logic [csd_pkg::SpeedW-1:0] train_speed,
	input  logic [3:0]                 aspect_cur,
	output logic [3:0]                 aspect_next,
	output logic                       changed,
	output logic                       overspeed
);

	csd_pkg::aspect_entry_t entry;

	assign entry = csd_pkg::aspect_lookup(main_freq_tenths);

	// Unknown codes keep the aspect
	assign aspect_next = entry.hit ? entry.code : aspect_cur;
	assign overspeed   = entry.hit && (train_speed > entry.limit);
	assign changed     = (aspect_next != aspect_cur) &&
	                     (aspect_cur != csd_pkg::ASPECT_NONE) &&
	                     (aspect_next != csd_pkg::ASPECT_NONE);

endmodule

// ----- rtl/csd_tone_ctl.sv -----
module csd_tone_ctl (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      advance,
	input  logic [csd_pkg::ToneW-1:0] secondary_freq,
	input  logic [csd_pkg::ToneW-1:0] side_freq,
	output csd_pkg::tone_res_t        res
);

	logic [csd_pkg::ToneW-1:0] prev_sec_q;
	logic                      section_q, panto_q, arm_one_q, arm_two_q;
	logic [1:0]                side_switch_q, side_result_q;

	logic       section_n, panto_n, arm_one_n, arm_two_n;
	logic [1:0] side_switch_n, side_result_n, side;

	function automatic logic tone_edge(input logic [csd_pkg::ToneW-1:0] now,
		input logic [csd_pkg::ToneW-1:0] prev, input logic [csd_pkg::ToneW-1:0] tone);
		return (now == tone) && (prev != tone);
	endfunction

	always_comb begin
		if (side_freq == csd_pkg::SIDE_ONE_A || side_freq == csd_pkg::SIDE_ONE_B) begin
			side = csd_pkg::SIDE_ONE;
		end else if (side_freq == csd_pkg::SIDE_TWO_A || side_freq == csd_pkg::SIDE_TWO_B) begin
			side = csd_pkg::SIDE_TWO;
		end else begin
			side = csd_pkg::SIDE_NONE;
		end

		section_n = section_q;
		if (secondary_freq == csd_pkg::TONE_SECTION_SET) begin
			section_n = 1'b1;
		end else if (secondary_freq == csd_pkg::TONE_SECTION_CLR) begin
			section_n = 1'b0;
		end

		panto_n = panto_q;
		if (secondary_freq == csd_pkg::TONE_PANTO_SET) begin
			panto_n = 1'b1;
		end else if (secondary_freq == csd_pkg::TONE_PANTO_CLR) begin
			panto_n = 1'b0;
		end

		arm_one_n = arm_one_q;
		arm_two_n = arm_two_q;
		if (tone_edge(secondary_freq, prev_sec_q, csd_pkg::TONE_DISARM_TWO_A) ||
		    tone_edge(secondary_freq, prev_sec_q, csd_pkg::TONE_DISARM_TWO_B)) begin
			arm_two_n = 1'b0;
		end
		if (tone_edge(secondary_freq, prev_sec_q, csd_pkg::TONE_ARM_TWO_A) ||
		    tone_edge(secondary_freq, prev_sec_q, csd_pkg::TONE_ARM_TWO_B)) begin
			arm_two_n = 1'b1;
			arm_one_n = 1'b0;
		end else if (tone_edge(secondary_freq, prev_sec_q, csd_pkg::TONE_ARM_ONE_A) ||
		             tone_edge(secondary_freq, prev_sec_q, csd_pkg::TONE_ARM_ONE_B)) begin
			arm_one_n = 1'b1;
			arm_two_n = 1'b0;
		end

		// Arming wins; otherwise the side tone is judged against the last armed side
		side_switch_n = side_switch_q;
		side_result_n = side_result_q;
		priority if (arm_one_n) begin
			side_result_n = csd_pkg::SIDE_ONE;
			side_switch_n = csd_pkg::SIDE_ONE;
		end else if (arm_two_n) begin
			side_result_n = csd_pkg::SIDE_TWO;
			side_switch_n = csd_pkg::SIDE_TWO;
		end else if (side_switch_q == csd_pkg::SIDE_ONE && side == csd_pkg::SIDE_ONE) begin
			side_result_n = csd_pkg::SIDE_ONE;
		end else if (side_switch_q == csd_pkg::SIDE_ONE && side == csd_pkg::SIDE_TWO) begin
			side_result_n = csd_pkg::SIDE_NONE;
		end else if (side_switch_q == csd_pkg::SIDE_TWO && side == csd_pkg::SIDE_ONE) begin
			side_result_n = csd_pkg::SIDE_NONE;
		end else if (side_switch_q == csd_pkg::SIDE_TWO && side == csd_pkg::SIDE_TWO) begin
			side_result_n = csd_pkg::SIDE_TWO;
		end else if (side_switch_q == csd_pkg::SIDE_NONE) begin
			side_result_n = csd_pkg::SIDE_UNDET;
		end else begin
			side_result_n = side_result_q;
		end

		res.section     = section_n;
		res.pantograph  = panto_n;
		res.side        = side_result_n;
		res.kv_edge     = tone_edge(secondary_freq, prev_sec_q, csd_pkg::TONE_KV65);
		res.square_edge = tone_edge(secondary_freq, prev_sec_q, csd_pkg::TONE_CARRE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_sec_q    <= '0;
			section_q     <= 1'b0;
			panto_q       <= 1'b0;
			arm_one_q     <= 1'b0;
			arm_two_q     <= 1'b0;
			side_switch_q <= csd_pkg::SIDE_NONE;
			side_result_q <= csd_pkg::SIDE_NONE;
		end else if (advance) begin
			prev_sec_q    <= secondary_freq;
			section_q     <= section_n;
			panto_q       <= panto_n;
			arm_one_q     <= arm_one_n;
			arm_two_q     <= arm_two_n;
			side_switch_q <= side_switch_n;
			side_result_q <= side_result_n;
		end
	end

	a_arm_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		!(arm_one_q && arm_two_q))
		else $error("both sides armed");

	a_switch_range: assert property (@(posedge clk) disable iff (!arst_n)
		side_switch_q != csd_pkg::SIDE_UNDET)
		else $error("side switch holds undetermined code");

	a_prev_tracks: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> prev_sec_q == $past(secondary_freq))
		else $error("previous secondary tone not updated");

endmodule

// ----- rtl/cab_signal_code_decoder.sv -----
// Channel  | Handshake                    | Payload
// item     | item_valid / item_stall      | csd_pkg::item_t   (main, secondary, side, speed)
// result   | result_valid / result_stall  | csd_pkg::result_t (aspect, flags, side, brake)
//
// One item per cycle while the result is not stalled. An input register feeds the
// decode logic, which loads the result register and the decoder state in the same
// edge, so each result follows its item through both registers.
// Reset clears the decoder state and both valid bits; no aspect is shown until
// a known main code arrives.
// A stalled result holds the result register; the input register then holds
// and item_stall rises while it is full.
module cab_signal_code_decoder (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             item_valid,
	output logic             item_stall,
	input  csd_pkg::item_t   item,
	output logic             result_valid,
	input  logic             result_stall,
	output csd_pkg::result_t result
);

	logic             valid_s1;
	csd_pkg::item_t   item_s1;
	logic             result_valid_q;
	csd_pkg::result_t result_q;
	logic [3:0]       aspect_q;
	logic             advance;

	logic [3:0]          aspect_next;
	logic                changed, overspeed, emergency;
	csd_pkg::tone_res_t  tone;

	assign advance    = valid_s1 && (!result_valid_q || !result_stall);
	assign item_stall = valid_s1 && result_valid_q && result_stall;

	csd_aspect_dec u_aspect (
		.main_freq_tenths (item_s1.main_freq_tenths),
		.train_speed      (item_s1.train_speed),
		.aspect_cur       (aspect_q),
		.aspect_next      (aspect_next),
		.changed          (changed),
		.overspeed        (overspeed)
	);

	csd_tone_ctl u_tone (
		.clk            (clk),
		.arst_n         (arst_n),
		.advance        (advance),
		.secondary_freq (item_s1.secondary_freq),
		.side_freq      (item_s1.side_freq),
		.res            (tone)
	);

	assign emergency = overspeed ||
	                   (tone.kv_edge && item_s1.main_freq_tenths == csd_pkg::MAIN_KV65) ||
	                   (tone.square_edge && item_s1.main_freq_tenths == csd_pkg::MAIN_CARRE);

	// Input register: load whenever it is empty or draining this cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!item_stall) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && !item_stall) begin
			item_s1 <= item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
			aspect_q       <= csd_pkg::ASPECT_NONE;
		end else begin
			if (!result_valid_q || !result_stall) begin
				result_valid_q <= valid_s1;
			end
			if (advance) begin
				aspect_q <= aspect_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_q.aspect_code     <= aspect_next;
			result_q.aspect_changed  <= changed;
			result_q.overspeed       <= overspeed;
			result_q.section_flag    <= tone.section;
			result_q.pantograph_flag <= tone.pantograph;
			result_q.active_side     <= tone.side;
			result_q.emergency_brake <= emergency;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

	a_aspect_match: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid_q |-> result_q.aspect_code == aspect_q)
		else $error("shown aspect differs from held aspect");

	a_over_brakes: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid_q && result_q.overspeed |-> result_q.emergency_brake)
		else $error("overspeed without emergency brake");

	a_no_drop: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1)
		else $error("held item lost from input register");

	a_changed_known: assert property (@(posedge clk) disable iff (!arst_n)
		advance && changed |=> aspect_q != $past(aspect_q))
		else $error("change pulse without aspect change");

endmodule

// ----- sim/cab_code_checker.sv -----
module cab_code_checker (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             item_valid,
	input  logic             item_stall,
	input  csd_pkg::item_t   item,
	input  logic             result_valid,
	input  logic             result_stall,
	input  csd_pkg::result_t result,
	output int               fail_count,
	output int               outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef enum logic [3:0] {
		ASP_NONE, ASP_300V, ASP_300C, ASP_270V, ASP_270C, ASP_270A, ASP_220A,
		ASP_220E, ASP_160A, ASP_160E, ASP_080A, ASP_080E, ASP_000R, ASP_RRRR
	} aspect_t;

	aspect_t                   shown_aspect;
	aspect_t                   last_aspect;
	logic [csd_pkg::ToneW-1:0] last_tone;
	logic                      section_on;
	logic                      panto_on;
	logic                      armed_one;
	logic                      armed_two;
	logic [1:0]                side_mode;
	logic [1:0]                side_out;
	csd_pkg::result_t          pending_decodes[$];
	int                        errs = 0;

	assign fail_count = errs;

	function automatic csd_pkg::result_t decode_cab_code(input csd_pkg::item_t it);
		csd_pkg::result_t           r;
		aspect_t                    code;
		logic [csd_pkg::SpeedW-1:0] lim;
		logic                       hit;
		logic [1:0]                 heard;
		logic                       fresh;
		logic                       kv, sq;
		hit  = 1'b1;
		code = ASP_NONE;
		lim  = '0;
		case (it.main_freq_tenths)
			10'd114: begin code = ASP_300V; lim = 9'd315; end
			10'd136: begin code = ASP_300C; lim = 9'd315; end
			10'd103: begin code = ASP_270V; lim = 9'd285; end
			10'd125: begin code = ASP_270C; lim = 9'd285; end
			10'd169: begin code = ASP_270A; lim = 9'd315; end
			10'd147: begin code = ASP_220A; lim = 9'd285; end
			10'd158: begin code = ASP_220E; lim = 9'd235; end
			10'd180: begin code = ASP_160A; lim = 9'd235; end
			10'd191: begin code = ASP_160E; lim = 9'd170; end
			10'd202: begin code = ASP_080A; lim = 9'd170; end
			10'd224: begin code = ASP_080E; lim = 9'd90;  end
			10'd246: begin code = ASP_000R; lim = 9'd90;  end
			10'd290: begin code = ASP_RRRR; lim = 9'd35;  end
			default: hit = 1'b0;
		endcase
		// unknown carrier: hold the aspect
		if (hit)
			shown_aspect = code;

		r.aspect_changed = (last_aspect != shown_aspect) && (shown_aspect != ASP_NONE)
			&& (last_aspect != ASP_NONE);
		r.overspeed = hit && (it.train_speed > lim);

		if (it.side_freq == csd_pkg::SIDE_ONE_A || it.side_freq == csd_pkg::SIDE_ONE_B)
			heard = csd_pkg::SIDE_ONE;
		else if (it.side_freq == csd_pkg::SIDE_TWO_A || it.side_freq == csd_pkg::SIDE_TWO_B)
			heard = csd_pkg::SIDE_TWO;
		else
			heard = csd_pkg::SIDE_NONE;

		if (it.secondary_freq == csd_pkg::TONE_SECTION_SET)
			section_on = 1'b1;
		else if (it.secondary_freq == csd_pkg::TONE_SECTION_CLR)
			section_on = 1'b0;

		// edge events fire only on the first tick of a tone
		fresh = it.secondary_freq != last_tone;
		sq = fresh && it.secondary_freq == csd_pkg::TONE_CARRE;
		kv = fresh && it.secondary_freq == csd_pkg::TONE_KV65;

		if (fresh && (it.secondary_freq == csd_pkg::TONE_DISARM_TWO_A ||
				it.secondary_freq == csd_pkg::TONE_DISARM_TWO_B))
			armed_two = 1'b0;
		if (fresh && (it.secondary_freq == csd_pkg::TONE_ARM_TWO_A ||
				it.secondary_freq == csd_pkg::TONE_ARM_TWO_B)) begin
			armed_two = 1'b1;
			armed_one = 1'b0;
		end else if (fresh && (it.secondary_freq == csd_pkg::TONE_ARM_ONE_A ||
				it.secondary_freq == csd_pkg::TONE_ARM_ONE_B)) begin
			armed_one = 1'b1;
			armed_two = 1'b0;
		end

		if (it.secondary_freq == csd_pkg::TONE_PANTO_SET)
			panto_on = 1'b1;
		else if (it.secondary_freq == csd_pkg::TONE_PANTO_CLR)
			panto_on = 1'b0;

		if (armed_one) begin
			side_out  = csd_pkg::SIDE_ONE;
			side_mode = csd_pkg::SIDE_ONE;
		end else if (armed_two) begin
			side_out  = csd_pkg::SIDE_TWO;
			side_mode = csd_pkg::SIDE_TWO;
		end else if (side_mode == csd_pkg::SIDE_ONE && heard == csd_pkg::SIDE_ONE) begin
			side_out = csd_pkg::SIDE_ONE;
		end else if (side_mode == csd_pkg::SIDE_ONE && heard == csd_pkg::SIDE_TWO) begin
			side_out = csd_pkg::SIDE_NONE;
		end else if (side_mode == csd_pkg::SIDE_TWO && heard == csd_pkg::SIDE_ONE) begin
			side_out = csd_pkg::SIDE_NONE;
		end else if (side_mode == csd_pkg::SIDE_TWO && heard == csd_pkg::SIDE_TWO) begin
			side_out = csd_pkg::SIDE_TWO;
		end else if (side_mode == csd_pkg::SIDE_NONE) begin
			side_out = csd_pkg::SIDE_UNDET;
		end
		// no rule matched: side_out holds

		r.emergency_brake = r.overspeed ||
			(kv && it.main_freq_tenths == csd_pkg::MAIN_KV65) ||
			(sq && it.main_freq_tenths == csd_pkg::MAIN_CARRE);

		last_aspect = shown_aspect;
		last_tone   = it.secondary_freq;

		r.aspect_code     = shown_aspect;
		r.section_flag    = section_on;
		r.pantograph_flag = panto_on;
		r.active_side     = side_out;
		return r;
	endfunction

	task automatic check_field(input string name, input logic [3:0] want, input logic [3:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			errs++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		csd_pkg::result_t want;
		if (!arst_n) begin
			shown_aspect = ASP_NONE;
			last_aspect  = ASP_NONE;
			last_tone    = '0;
			section_on   = 1'b0;
			panto_on     = 1'b0;
			armed_one    = 1'b0;
			armed_two    = 1'b0;
			side_mode    = csd_pkg::SIDE_NONE;
			side_out     = csd_pkg::SIDE_NONE;
			pending_decodes.delete();
			outstanding <= 0;
		end else begin
			if (item_valid && !item_stall)
				pending_decodes.push_back(decode_cab_code(item));
			if (result_valid && !result_stall) begin
				if (pending_decodes.size() == 0) begin
					$error("result transfer with no decode pending");
					errs++;
				end else begin
					want = pending_decodes.pop_front();
					check_field("aspect_code", want.aspect_code, result.aspect_code);
					check_field("aspect_changed", 4'(want.aspect_changed),
						4'(result.aspect_changed));
					check_field("overspeed", 4'(want.overspeed), 4'(result.overspeed));
					check_field("section_flag", 4'(want.section_flag),
						4'(result.section_flag));
					check_field("pantograph_flag", 4'(want.pantograph_flag),
						4'(result.pantograph_flag));
					check_field("active_side", 4'(want.active_side),
						4'(result.active_side));
					check_field("emergency_brake", 4'(want.emergency_brake),
						4'(result.emergency_brake));
				end
			end
			outstanding <= pending_decodes.size();
		end
	end

endmodule

// ----- sim/tb.sv -----
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	typedef enum int {FLOW, LIGHT, HEAVY, CHOKE} stall_mode_t;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             item_valid = 1'b0;
	logic             item_stall;
	csd_pkg::item_t   item = '0;
	logic             result_valid;
	logic             result_stall = 1'b0;
	csd_pkg::result_t result;
	int               fail_count;
	int               outstanding;
	stall_mode_t      stall_mode = FLOW;
	int               stall_left = 0;

	cab_signal_code_decoder dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	cab_code_checker checker_i (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result),
		.fail_count   (fail_count),
		.outstanding  (outstanding)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// receiver: switch at random between stall densities
	always @(posedge clk) begin
		if (stall_left == 0) begin
			stall_mode <= stall_mode_t'($urandom_range(0, 3));
			stall_left <= $urandom_range(8, 40);
		end else begin
			stall_left <= stall_left - 1;
		end
		case (stall_mode)
			FLOW:    result_stall <= 1'b0;
			LIGHT:   result_stall <= ($urandom_range(0, 3) == 0);
			HEAVY:   result_stall <= ($urandom_range(0, 1) == 0);
			default: result_stall <= ($urandom_range(0, 7) != 0);
		endcase
	end

	// known carrier k with the speed set right at its limit
	function automatic csd_pkg::item_t known_item(input int k);
		csd_pkg::item_t x;
		x = '0;
		case (k)
			0:  begin x.main_freq_tenths = 10'd114; x.train_speed = 9'd315; end
			1:  begin x.main_freq_tenths = 10'd136; x.train_speed = 9'd315; end
			2:  begin x.main_freq_tenths = 10'd103; x.train_speed = 9'd285; end
			3:  begin x.main_freq_tenths = 10'd125; x.train_speed = 9'd285; end
			4:  begin x.main_freq_tenths = 10'd169; x.train_speed = 9'd315; end
			5:  begin x.main_freq_tenths = 10'd147; x.train_speed = 9'd285; end
			6:  begin x.main_freq_tenths = 10'd158; x.train_speed = 9'd235; end
			7:  begin x.main_freq_tenths = 10'd180; x.train_speed = 9'd235; end
			8:  begin x.main_freq_tenths = 10'd191; x.train_speed = 9'd170; end
			9:  begin x.main_freq_tenths = 10'd202; x.train_speed = 9'd170; end
			10: begin x.main_freq_tenths = 10'd224; x.train_speed = 9'd90;  end
			11: begin
				x.main_freq_tenths = csd_pkg::MAIN_KV65;
				x.train_speed = 9'd90;
			end
			default: begin
				x.main_freq_tenths = csd_pkg::MAIN_CARRE;
				x.train_speed = 9'd35;
			end
		endcase
		return x;
	endfunction

	function automatic logic [csd_pkg::ToneW-1:0] tone_by_index(input int n);
		case (n)
			0:       return csd_pkg::TONE_SECTION_SET;
			1:       return csd_pkg::TONE_SECTION_CLR;
			2:       return csd_pkg::TONE_PANTO_SET;
			3:       return csd_pkg::TONE_PANTO_CLR;
			4:       return csd_pkg::TONE_CARRE;
			5:       return csd_pkg::TONE_KV65;
			6:       return csd_pkg::TONE_DISARM_TWO_A;
			7:       return csd_pkg::TONE_DISARM_TWO_B;
			8:       return csd_pkg::TONE_ARM_TWO_A;
			9:       return csd_pkg::TONE_ARM_TWO_B;
			10:      return csd_pkg::TONE_ARM_ONE_A;
			11:      return csd_pkg::TONE_ARM_ONE_B;
			default: return 12'($urandom_range(0, 4095));
		endcase
	endfunction

	function automatic logic [csd_pkg::ToneW-1:0] side_by_index(input int n);
		case (n)
			0:       return csd_pkg::SIDE_ONE_A;
			1:       return csd_pkg::SIDE_ONE_B;
			2:       return csd_pkg::SIDE_TWO_A;
			3:       return csd_pkg::SIDE_TWO_B;
			default: return 12'($urandom_range(0, 4095));
		endcase
	endfunction

	task automatic send_item(input csd_pkg::item_t x);
		item       <= x;
		item_valid <= 1'b1;
		do @(posedge clk); while (item_stall);
	endtask

	initial begin
		csd_pkg::item_t            x;
		logic [csd_pkg::ToneW-1:0] held_tone;
		int                        sent;
		int                        burst;
		int                        gap;
		int                        k;

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// field extremes, all unknown carriers
		x = '0;
		send_item(x);
		x = '{main_freq_tenths: 10'd1023, secondary_freq: 12'd4095, side_freq: 12'd4095,
			train_speed: 9'd511};
		send_item(x);

		// every aspect, alternating at and just over the limit, each with a tone
		for (int i = 0; i < 13; i++) begin
			x = known_item(i);
			if (i % 2)
				x.train_speed = x.train_speed + 9'd1;
			x.secondary_freq = tone_by_index(i);
			x.side_freq = side_by_index(i % 5);
			send_item(x);
		end

		// tone edges under their carriers, then the same tone held
		x = known_item(11);
		x.train_speed = '0;
		x.secondary_freq = csd_pkg::TONE_KV65;
		send_item(x);
		send_item(x);
		x = known_item(12);
		x.train_speed = '0;
		x.secondary_freq = csd_pkg::TONE_CARRE;
		send_item(x);
		send_item(x);

		// unknown carrier at full speed holds the aspect without overspeed
		x = '{main_freq_tenths: 10'd500, secondary_freq: 12'd0, side_freq: 12'd0,
			train_speed: 9'd511};
		send_item(x);
		x = known_item(12);
		x.train_speed = 9'd36;
		send_item(x);

		// arm side two, disarm, then steer by side tones alone
		x = known_item(0);
		x.secondary_freq = csd_pkg::TONE_ARM_TWO_A;
		send_item(x);
		x.secondary_freq = csd_pkg::TONE_DISARM_TWO_A;
		x.side_freq = csd_pkg::SIDE_ONE_A;
		send_item(x);
		x.side_freq = csd_pkg::SIDE_TWO_B;
		send_item(x);
		x.side_freq = 12'd5;
		send_item(x);
		held_tone = x.secondary_freq;

		sent = 0;
		while (sent < 400) begin
			burst = $urandom_range(1, 12);
			for (int b = 0; b < burst; b++) begin
				k = $urandom_range(0, 15);
				if (k < 13) begin
					x = known_item(k);
					if ($urandom_range(0, 4) < 3)
						x.train_speed = x.train_speed + 9'($urandom_range(0, 4)) - 9'd2;
					else
						x.train_speed = 9'($urandom_range(0, 511));
				end else begin
					x.main_freq_tenths = 10'($urandom_range(0, 1023));
					x.train_speed = 9'($urandom_range(0, 511));
				end
				case ($urandom_range(0, 9))
					0, 1, 2, 3: x.secondary_freq = held_tone;
					4, 5, 6, 7: x.secondary_freq = tone_by_index($urandom_range(0, 11));
					default:    x.secondary_freq = 12'($urandom_range(0, 4095));
				endcase
				// drive the braking combinations now and then
				if ($urandom_range(0, 9) == 0) begin
					if ($urandom_range(0, 1)) begin
						x.main_freq_tenths = csd_pkg::MAIN_KV65;
						x.secondary_freq = csd_pkg::TONE_KV65;
					end else begin
						x.main_freq_tenths = csd_pkg::MAIN_CARRE;
						x.secondary_freq = csd_pkg::TONE_CARRE;
					end
				end
				x.side_freq = side_by_index($urandom_range(0, 7));
				held_tone = x.secondary_freq;
				send_item(x);
				sent++;
			end
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				item_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		item_valid <= 1'b0;

		do @(posedge clk); while (outstanding != 0);
		repeat (10) @(posedge clk);

		if (fail_count == 0)
			$display("cab_signal_code_decoder: match");
		else
			$display("cab_signal_code_decoder: mismatch");
		$finish;
	end

	initial begin
		#2000000;
		$display("cab_signal_code_decoder: mismatch");
		$finish;
	end

endmodule

// ----- cab_signal_code_decoder.f -----
rtl/csd_pkg.sv
rtl/csd_aspect_dec.sv
rtl/csd_tone_ctl.sv
rtl/cab_signal_code_decoder.sv
sim/cab_code_checker.sv
sim/tb.sv
